// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by expression_tokenizer
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising edge outside reset
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/extok_pkg.sv -----
// ---------------------------------------------------------------------------
// extok_pkg
// Token codes, character constants and the result record of the tokenizer
// ---------------------------------------------------------------------------
package extok_pkg;

  // fixed field widths of one result
  localparam int NUM_W  = 48;
  localparam int TEXT_W = 64;
  localparam int LEN_W  = 4;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [2:0] {
    KIND_NUM  = 3'd0,
    KIND_NAME = 3'd1,
    KIND_OP   = 3'd2,
    KIND_LP   = 3'd3,
    KIND_RP   = 3'd4,
    KIND_UNK  = 3'd5,
    KIND_END  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    OP_PLUS  = 3'd0,
    OP_MINUS = 3'd1,
    OP_TIMES = 3'd2,
    OP_DIV   = 3'd3,
    OP_POW   = 3'd4
  } op_t;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // one result token
  typedef struct packed {
    kind_t              kind;
    logic [NUM_W-1:0]   num;
    logic [TEXT_W-1:0]  text;
    logic [LEN_W-1:0]   len;
    op_t                op;
    logic               ovf;
    logic               last;
  } tok_t;

endpackage

// ----- hdl/expression_tokenizer.sv -----
// ---------------------------------------------------------------------------
// expression_tokenizer
// Byte-stream lexer for arithmetic expressions: numbers, names, operators
//   in_*  channel carries one expression byte per transaction in in_tdata;
//         in_tlast closes the expression (the byte is then ignored), which
//         flushes a pending number or name and emits an end token.
//   out_* channel carries one token per transaction, token kind in out_tuser,
//         out_tlast on the last token caused by an input byte.
//   Each token is registered into the output queue, whose head drives out_*.
//   Throughput: one byte per cycle while the queue has room. A byte that
//   emits two tokens (a flushed number or name followed by an operator,
//   paren, unknown or end token) costs one extra cycle, set by the three-entry
//   output queue that must hold two free slots before in_tready rises.
//   Fractions are converted to binary one digit at a time as they arrive,
//   keeping quotient and remainder against 10^FRAC_DIGITS, so a number is
//   ready the cycle its terminating byte shows up.
//   Reset (rst_n low, synchronous) clears the scanner and empties the queue.
//   When the receiver stalls, tokens wait in the queue; in_tready drops once
//   more than one token is queued and the scanner holds its state.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module expression_tokenizer #(
  parameter int INT_BITS    = 32,
  parameter int FRAC_BITS   = 16,
  parameter int FRAC_DIGITS = 5,
  parameter int NAME_CHARS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] char_in
  input  logic                                in_tlast,   // expression_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [47:0] number_value, [111:48] name_text, [115:112] name_length,
  // [118:116] operator_code, [119] overflow_flag
  output logic [extok_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [2:0]                          out_tuser,  // [2:0] token_kind
  output logic                                out_tlast   // last_of_run
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_INT  = 2'd1,
    MODE_FRAC = 2'd2,
    MODE_NAME = 2'd3
  } mode_t;

  // derived sizes
  localparam int unsigned P_DEC = 10 ** FRAC_DIGITS;
  localparam int RM_W   = $clog2(P_DEC);
  localparam int RS_W   = RM_W + 4;
  localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);
  localparam int DI_W   = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam int QT_N   = 2 ** DI_W;
  localparam int NCNT_W = $clog2(NAME_CHARS + 1);
  localparam int NBUF_W = 8 * NAME_CHARS;
  localparam int NUMV_W = INT_BITS + FRAC_BITS;
  localparam logic [RM_W-1:0]     HALF_P = RM_W'(P_DEC / 2);
  localparam logic [INT_BITS-1:0] IMAX   = {INT_BITS{1'b1}};

  // quotient part of 2^FRAC_BITS / 10^(i+1) per fraction digit position
  function automatic logic [QT_N-1:0][FRAC_BITS-1:0] q_table();
    logic [QT_N-1:0][FRAC_BITS-1:0] t;
    logic [63:0] q;
    t = '0;
    q = 64'd1 << FRAC_BITS;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      q = q / 10;
      t[i] = q[FRAC_BITS-1:0];
    end
    return t;
  endfunction

  // matching remainder against 10^FRAC_DIGITS per position
  function automatic logic [QT_N-1:0][RM_W-1:0] r_table();
    logic [QT_N-1:0][RM_W-1:0] t;
    logic [63:0] q;
    logic [63:0] w;
    logic [63:0] r;
    t = '0;
    q = 64'd1 << FRAC_BITS;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      q = q / 10;
      w = 64'd1;
      for (int j = i + 1; j < FRAC_DIGITS; j++) begin
        w = w * 64'd10;
      end
      r = ((64'd1 << FRAC_BITS) * w) - (q * 64'(P_DEC));
      t[i] = r[RM_W-1:0];
    end
    return t;
  endfunction

  // multiples of 10^FRAC_DIGITS for remainder reduction
  function automatic logic [15:0][RS_W-1:0] kp_table();
    logic [15:0][RS_W-1:0] t;
    t = '0;
    for (int j = 0; j < 10; j++) begin
      t[j] = RS_W'(j * P_DEC);
    end
    return t;
  endfunction

  localparam logic [QT_N-1:0][FRAC_BITS-1:0] QW_TAB = q_table();
  localparam logic [QT_N-1:0][RM_W-1:0]      RW_TAB = r_table();
  localparam logic [15:0][RS_W-1:0]          KP_TAB = kp_table();

  // scanner state
  mode_t                 mode_r, mode_nxt;
  logic [INT_BITS-1:0]   int_acc_r, int_acc_nxt;
  logic [FRAC_BITS-1:0]  frac_q_r, frac_q_nxt;
  logic [RM_W-1:0]       frac_rem_r, frac_rem_nxt;
  logic [FCNT_W-1:0]     frac_cnt_r, frac_cnt_nxt;
  logic [NBUF_W-1:0]     name_buf_r, name_buf_nxt;
  logic [NCNT_W-1:0]     name_cnt_r, name_cnt_nxt;
  logic                  ovf_r, ovf_nxt;

  // output queue, entry 0 is the head
  extok_pkg::tok_t       q_r [3];
  extok_pkg::tok_t       q_nxt [3];
  logic [1:0]            q_cnt_r, q_cnt_nxt;

  logic                  accept;
  logic                  pop;
  logic [7:0]            ch;
  logic [3:0]            digit;
  logic                  is_digit, is_letter, is_space;

  logic [INT_BITS+3:0]   int_prod;
  logic                  int_sat;
  logic [INT_BITS-1:0]   int_step;

  logic [DI_W-1:0]       fidx;
  logic                  frac_room;
  logic [FRAC_BITS+3:0]  q_prod;
  logic [RS_W-1:0]       r_prod;
  logic [RS_W-1:0]       r_sum;
  logic [RS_W-1:0]       r_left;
  logic [3:0]            k_sel;

  logic                  round_up;
  logic [FRAC_BITS:0]    fsum;
  logic [INT_BITS-1:0]   ipart;
  logic [FRAC_BITS-1:0]  fpart;
  logic                  num_ovf;
  logic [NUMV_W-1:0]     num_wide;
  logic [63:0]           num64;

  logic                  do_flush, do_start, byte_res;
  logic                  flush_valid, second_valid;
  logic [1:0]            n_res;
  extok_pkg::tok_t       flush_tok, sec_tok, res0, res1;
  extok_pkg::kind_t      byte_kind;
  extok_pkg::op_t        byte_op;
  logic [1:0]            base;

  assign ch    = in_tdata;
  assign digit = in_tdata[3:0];

  // character classes
  assign is_digit  = (ch >= extok_pkg::CH_ZERO) && (ch <= extok_pkg::CH_NINE);
  assign is_letter = ((ch >= extok_pkg::CH_UA) && (ch <= extok_pkg::CH_UZ)) ||
                     ((ch >= extok_pkg::CH_LA) && (ch <= extok_pkg::CH_LZ));
  assign is_space  = ((ch >= extok_pkg::CH_TAB) && (ch <= extok_pkg::CH_CR)) ||
                     (ch == extok_pkg::CH_SPACE);

  // integer digit step with saturation
  assign int_prod = ({4'b0, int_acc_r} << 3) + ({4'b0, int_acc_r} << 1) +
                    (INT_BITS+4)'(digit);
  assign int_sat  = |int_prod[INT_BITS+3:INT_BITS];
  assign int_step = int_sat ? IMAX : int_prod[INT_BITS-1:0];

  // fraction digit step: quotient and remainder of the scaled fraction
  assign fidx      = frac_cnt_r[DI_W-1:0];
  assign frac_room = frac_cnt_r < FCNT_W'(FRAC_DIGITS);
  assign q_prod    = {{FRAC_BITS{1'b0}}, digit} * {4'b0, QW_TAB[fidx]};
  assign r_prod    = {{RM_W{1'b0}}, digit} * {4'b0, RW_TAB[fidx]};
  assign r_sum     = r_prod + {4'b0, frac_rem_r};

  always_comb begin
    k_sel = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (r_sum >= KP_TAB[j]) begin
        k_sel = 4'(j);
      end
    end
  end

  assign r_left = r_sum - KP_TAB[k_sel];

  // number token value with rounding carry into the integer part
  assign round_up = frac_rem_r >= HALF_P;
  assign fsum     = {1'b0, frac_q_r} + (FRAC_BITS+1)'(round_up);

  always_comb begin
    ipart   = int_acc_r;
    fpart   = fsum[FRAC_BITS-1:0];
    num_ovf = ovf_r;
    if (fsum[FRAC_BITS]) begin
      if (int_acc_r == IMAX) begin
        fpart   = {FRAC_BITS{1'b1}};
        num_ovf = 1'b1;
      end else begin
        ipart = int_acc_r + INT_BITS'(1);
      end
    end
  end

  assign num_wide = {ipart, fpart};
  assign num64    = 64'(num_wide);

  // pending token as it stands before this byte
  always_comb begin
    flush_tok = '0;
    if (mode_r == MODE_NAME) begin
      flush_tok.kind = extok_pkg::KIND_NAME;
      flush_tok.text = extok_pkg::TEXT_W'(name_buf_r);
      flush_tok.len  = extok_pkg::LEN_W'(name_cnt_r);
      flush_tok.ovf  = ovf_r;
    end else begin
      flush_tok.kind = extok_pkg::KIND_NUM;
      flush_tok.num  = num64[extok_pkg::NUM_W-1:0];
      flush_tok.ovf  = num_ovf;
    end
  end

  // single-byte token decode
  always_comb begin
    byte_kind = extok_pkg::KIND_OP;
    byte_op   = extok_pkg::OP_PLUS;
    unique case (ch)
      extok_pkg::CH_PLUS:  byte_op = extok_pkg::OP_PLUS;
      extok_pkg::CH_MINUS: byte_op = extok_pkg::OP_MINUS;
      extok_pkg::CH_STAR:  byte_op = extok_pkg::OP_TIMES;
      extok_pkg::CH_SLASH: byte_op = extok_pkg::OP_DIV;
      extok_pkg::CH_CARET: byte_op = extok_pkg::OP_POW;
      extok_pkg::CH_LPAR:  byte_kind = extok_pkg::KIND_LP;
      extok_pkg::CH_RPAR:  byte_kind = extok_pkg::KIND_RP;
      default:             byte_kind = extok_pkg::KIND_UNK;
    endcase
  end

  // scanner next state
  always_comb begin
    mode_nxt     = mode_r;
    int_acc_nxt  = int_acc_r;
    frac_q_nxt   = frac_q_r;
    frac_rem_nxt = frac_rem_r;
    frac_cnt_nxt = frac_cnt_r;
    name_buf_nxt = name_buf_r;
    name_cnt_nxt = name_cnt_r;
    ovf_nxt      = ovf_r;
    do_flush     = 1'b0;
    do_start     = 1'b0;
    byte_res     = 1'b0;

    if (in_tlast) begin
      do_flush = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_INT: begin
          if (is_digit) begin
            int_acc_nxt = int_step;
            ovf_nxt     = ovf_r | int_sat;
          end else if (ch == extok_pkg::CH_DOT) begin
            mode_nxt = MODE_FRAC;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            if (frac_room) begin
              frac_q_nxt   = frac_q_r + q_prod[FRAC_BITS-1:0] + FRAC_BITS'(k_sel);
              frac_rem_nxt = r_left[RM_W-1:0];
              frac_cnt_nxt = frac_cnt_r + FCNT_W'(1);
            end
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_NAME: begin
          if (is_letter) begin
            if (name_cnt_r < NCNT_W'(NAME_CHARS)) begin
              for (int j = 0; j < NAME_CHARS; j++) begin
                if (name_cnt_r == NCNT_W'(j)) begin
                  name_buf_nxt[8*j +: 8] = ch;
                end
              end
              name_cnt_nxt = name_cnt_r + NCNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    // flushing returns everything to idle
    if (do_flush) begin
      mode_nxt     = MODE_IDLE;
      int_acc_nxt  = '0;
      frac_q_nxt   = '0;
      frac_rem_nxt = '0;
      frac_cnt_nxt = '0;
      name_buf_nxt = '0;
      name_cnt_nxt = '0;
      ovf_nxt      = 1'b0;
    end

    // the byte opens a new token or stands alone
    if (do_start) begin
      if (is_space) begin
        byte_res = 1'b0;
      end else if (is_digit) begin
        mode_nxt    = MODE_INT;
        int_acc_nxt = INT_BITS'(digit);
      end else if (is_letter) begin
        mode_nxt     = MODE_NAME;
        name_buf_nxt = NBUF_W'(ch);
        name_cnt_nxt = NCNT_W'(1);
      end else begin
        byte_res = 1'b1;
      end
    end
  end

  // results of this byte
  assign flush_valid  = do_flush && (mode_r != MODE_IDLE);
  assign second_valid = in_tlast || byte_res;
  assign n_res        = {1'b0, flush_valid} + {1'b0, second_valid};

  always_comb begin
    sec_tok      = '0;
    sec_tok.kind = in_tlast ? extok_pkg::KIND_END : byte_kind;
    sec_tok.op   = (in_tlast || (byte_kind != extok_pkg::KIND_OP)) ?
                   extok_pkg::OP_PLUS : byte_op;
    sec_tok.last = 1'b1;
    res0         = flush_valid ? flush_tok : sec_tok;
    res0.last    = !(flush_valid && second_valid);
    res1         = sec_tok;
  end

  // output queue handshake
  assign in_tready  = q_cnt_r <= 2'd1;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = q_cnt_r != 2'd0;
  assign pop        = out_tvalid && out_tready;
  assign base       = q_cnt_r - {1'b0, pop};
  assign q_cnt_nxt  = base + (accept ? n_res : 2'd0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pop && (i < 2)) begin
        q_nxt[i] = q_r[(i < 2) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (accept && (n_res != 2'd0) && (base == 2'(i))) begin
        q_nxt[i] = res0;
      end
      if (accept && (n_res == 2'd2) && ((base + 2'd1) == 2'(i))) begin
        q_nxt[i] = res1;
      end
    end
  end

  // head entry drives the result port
  assign out_tuser = q_r[0].kind;
  assign out_tlast = q_r[0].last;
  assign out_tdata = {q_r[0].ovf, q_r[0].op, q_r[0].len, q_r[0].text, q_r[0].num};

  // scanner state and queue fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      int_acc_r  <= '0;
      frac_q_r   <= '0;
      frac_rem_r <= '0;
      frac_cnt_r <= '0;
      name_buf_r <= '0;
      name_cnt_r <= '0;
      ovf_r      <= 1'b0;
      q_cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        mode_r     <= mode_nxt;
        int_acc_r  <= int_acc_nxt;
        frac_q_r   <= frac_q_nxt;
        frac_rem_r <= frac_rem_nxt;
        frac_cnt_r <= frac_cnt_nxt;
        name_buf_r <= name_buf_nxt;
        name_cnt_r <= name_cnt_nxt;
        ovf_r      <= ovf_nxt;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // checks
  `ASSERT_CLKD(a_end_idle, clk, rst_n, (in_tvalid && in_tready && in_tlast) |=> (mode_r == MODE_IDLE), "scanner not idle after end marker")
  `ASSERT_CLKD(a_end_last, clk, rst_n, (out_tvalid && (out_tuser == extok_pkg::KIND_END)) |-> out_tlast, "end token without tlast")
  `ASSERT_CLKD(a_num_only, clk, rst_n, (out_tvalid && (out_tuser != extok_pkg::KIND_NUM)) |-> (out_tdata[47:0] == 48'd0), "number value on non-number token")
  `ASSERT_CLKD(a_rem_range, clk, rst_n, frac_rem_r < RM_W'(P_DEC), "fraction remainder out of range")
  `ASSERT_CLKD(a_no_overfill, clk, rst_n, (q_cnt_r == 2'd3) |=> (q_cnt_r != 2'd0) && !$past(in_tready), "queue overfilled")

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the expression tokenizer: a short table of
// hand-picked bytes followed by random expression text, every token on the
// output stream compared field by field against hand-typed tokens or a cycle-free scanner model.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INT_BITS     = 32;
  localparam int FRAC_BITS    = 16;
  localparam int FRAC_DIGITS  = 5;
  localparam int NAME_CHARS   = 8;
  localparam int CLK_PERIOD   = 8;
  localparam int RANDOM_ITEMS = 1650;
  localparam int PAUSE_AT     = 800;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTS   = 40;

  localparam logic [63:0] INT_MAX  = (64'd1 << INT_BITS) - 64'd1;
  localparam logic [63:0] FRAC_ONE = 64'd1 << FRAC_BITS;

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_INT  = 2'd1,
    SCAN_FRAC = 2'd2,
    SCAN_NAME = 2'd3
  } scan_t;

  // one byte to send, optionally with hand-typed expected tokens
  typedef struct packed {
    logic [7:0]      ch;
    logic            fin;
    logic [1:0]      n_typed;
    extok_pkg::tok_t t0;
    extok_pkg::tok_t t1;
  } stim_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata = 8'h00;
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [extok_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0]                       out_tuser;
  logic                             out_tlast;

  // scanner model state
  scan_t       scan_st;
  logic [63:0] int_acc;
  logic [63:0] frac_acc;
  int unsigned frac_cnt;
  logic [63:0] name_buf;
  int unsigned name_cnt;
  logic        ovf_pend;

  extok_pkg::tok_t step_toks[$];
  extok_pkg::tok_t pending_tokens[$];
  stim_t           stim_rows[$];

  int  err_count = 0;
  int  bytes_sent = 0;
  int  ends_sent = 0;
  int  tok_checked = 0;
  int  ovf_tokens = 0;
  int  kind_seen[7];
  bit  calm = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  expression_tokenizer #(
    .INT_BITS    (INT_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .FRAC_DIGITS (FRAC_DIGITS),
    .NAME_CHARS  (NAME_CHARS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // token record builder
  function automatic extok_pkg::tok_t tk(extok_pkg::kind_t kind, logic [47:0] num,
                                         logic [63:0] text, logic [3:0] len,
                                         extok_pkg::op_t op, logic ovf, logic last);
    extok_pkg::tok_t t;
    t.kind = kind;
    t.num  = num;
    t.text = text;
    t.len  = len;
    t.op   = op;
    t.ovf  = ovf;
    t.last = last;
    return t;
  endfunction

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= extok_pkg::CH_ZERO && ch <= extok_pkg::CH_NINE;
  endfunction

  function automatic bit is_letter(logic [7:0] ch);
    return (ch >= extok_pkg::CH_UA && ch <= extok_pkg::CH_UZ) ||
           (ch >= extok_pkg::CH_LA && ch <= extok_pkg::CH_LZ);
  endfunction

  // emit the pending number or name, then return to idle
  task automatic flush_pending();
    logic [63:0] ipart;
    logic [63:0] fpart;
    logic [63:0] pow10;
    logic        ovf;
    logic [63:0] value;
    ipart = int_acc;
    fpart = 64'd0;
    ovf   = ovf_pend;
    value = 64'd0;
    if (scan_st == SCAN_INT || scan_st == SCAN_FRAC) begin
      if (frac_cnt > 0) begin
        pow10 = 64'd1;
        for (int i = 0; i < frac_cnt; i++) pow10 = pow10 * 64'd10;
        fpart = ((frac_acc << FRAC_BITS) + pow10 / 64'd2) / pow10;
      end
      // rounding carry into the integer part, saturating at the top
      if (fpart >= FRAC_ONE) begin
        fpart = fpart - FRAC_ONE;
        if (ipart >= INT_MAX) begin
          ovf   = 1'b1;
          value = (INT_MAX << FRAC_BITS) | (FRAC_ONE - 64'd1);
        end else begin
          ipart = ipart + 64'd1;
        end
      end
      if (value == 64'd0) value = (ipart << FRAC_BITS) | fpart;
      step_toks.push_back(tk(extok_pkg::KIND_NUM, value[47:0], 64'd0, 4'd0,
                             extok_pkg::OP_PLUS, ovf, 1'b0));
    end else if (scan_st == SCAN_NAME) begin
      step_toks.push_back(tk(extok_pkg::KIND_NAME, 48'd0, name_buf, name_cnt[3:0],
                             extok_pkg::OP_PLUS, ovf_pend, 1'b0));
    end
    scan_st  = SCAN_IDLE;
    int_acc  = 64'd0;
    frac_acc = 64'd0;
    frac_cnt = 0;
    name_buf = 64'd0;
    name_cnt = 0;
    ovf_pend = 1'b0;
  endtask

  // scanner model: tokens caused by one accepted byte land in step_toks
  task automatic predict_tokens(logic [7:0] ch, logic fin);
    bit               consumed;
    logic [63:0]      digit;
    extok_pkg::kind_t bkind;
    extok_pkg::op_t   bop;
    consumed = 1'b0;
    digit    = {56'd0, ch - extok_pkg::CH_ZERO};
    step_toks.delete();
    if (fin) begin
      flush_pending();
      step_toks.push_back(tk(extok_pkg::KIND_END, 48'd0, 64'd0, 4'd0,
                             extok_pkg::OP_PLUS, 1'b0, 1'b0));
    end else begin
      // try to extend the pending token
      case (scan_st)
        SCAN_INT: begin
          if (is_digit(ch)) begin
            consumed = 1'b1;
            if (int_acc > (INT_MAX - digit) / 64'd10) begin
              int_acc  = INT_MAX;
              ovf_pend = 1'b1;
            end else begin
              int_acc = int_acc * 64'd10 + digit;
            end
          end else if (ch == extok_pkg::CH_DOT) begin
            consumed = 1'b1;
            scan_st  = SCAN_FRAC;
          end
        end
        SCAN_FRAC: begin
          if (is_digit(ch)) begin
            consumed = 1'b1;
            if (frac_cnt < FRAC_DIGITS) begin
              frac_acc = frac_acc * 64'd10 + digit;
              frac_cnt++;
            end
          end
        end
        SCAN_NAME: begin
          if (is_letter(ch)) begin
            consumed = 1'b1;
            if (name_cnt < NAME_CHARS) begin
              name_buf = name_buf | ({56'd0, ch} << (8 * name_cnt));
              name_cnt++;
            end else begin
              ovf_pend = 1'b1;
            end
          end
        end
        default: ;
      endcase
      // byte not absorbed: close the pending token and handle the byte fresh
      if (!consumed) begin
        flush_pending();
        if ((ch >= extok_pkg::CH_TAB && ch <= extok_pkg::CH_CR) ||
            ch == extok_pkg::CH_SPACE) begin
        end else if (is_digit(ch)) begin
          scan_st = SCAN_INT;
          int_acc = digit;
        end else if (is_letter(ch)) begin
          scan_st  = SCAN_NAME;
          name_buf = {56'd0, ch};
          name_cnt = 1;
        end else begin
          bkind = extok_pkg::KIND_OP;
          bop   = extok_pkg::OP_PLUS;
          case (ch)
            extok_pkg::CH_PLUS:  bop = extok_pkg::OP_PLUS;
            extok_pkg::CH_MINUS: bop = extok_pkg::OP_MINUS;
            extok_pkg::CH_STAR:  bop = extok_pkg::OP_TIMES;
            extok_pkg::CH_SLASH: bop = extok_pkg::OP_DIV;
            extok_pkg::CH_CARET: bop = extok_pkg::OP_POW;
            extok_pkg::CH_LPAR:  bkind = extok_pkg::KIND_LP;
            extok_pkg::CH_RPAR:  bkind = extok_pkg::KIND_RP;
            default:             bkind = extok_pkg::KIND_UNK;
          endcase
          step_toks.push_back(tk(bkind, 48'd0, 64'd0, 4'd0, bop, 1'b0, 1'b0));
        end
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endtask

  task automatic add_row(logic [7:0] ch, logic fin, logic [1:0] n,
                         extok_pkg::tok_t t0, extok_pkg::tok_t t1);
    stim_t row;
    row.ch      = ch;
    row.fin     = fin;
    row.n_typed = n;
    row.t0      = t0;
    row.t1      = t1;
    stim_rows.push_back(row);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 2'd0, '0, '0);
  endtask

  // random expression fragment, mostly well-formed tokens
  task automatic gen_fragment();
    int sel;
    int k;
    int n;
    int r;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      // number, sometimes at or beyond the integer limit
      k = $urandom_range(0, 19);
      if (k == 0) add_text("4294967295");
      else if (k == 1) add_text("4294967296");
      else begin
        n = (k == 2) ? $urandom_range(11, 14) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          add_row(8'(extok_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0, 2'd0, '0, '0);
      end
      if ($urandom_range(0, 2) == 0) begin
        add_row(extok_pkg::CH_DOT, 1'b0, 2'd0, '0, '0);
        n = $urandom_range(0, 7);
        r = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
          add_row((r == 0) ? extok_pkg::CH_NINE :
                  8'(extok_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0, 2'd0, '0, '0);
      end
    end else if (sel < 50) begin
      // name, occasionally longer than the buffer
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        add_row(8'((($urandom_range(0, 1) == 1) ? extok_pkg::CH_LA : extok_pkg::CH_UA) +
                   $urandom_range(0, 25)), 1'b0, 2'd0, '0, '0);
    end else if (sel < 70) begin
      case ($urandom_range(0, 6))
        0: add_row(extok_pkg::CH_PLUS, 1'b0, 2'd0, '0, '0);
        1: add_row(extok_pkg::CH_MINUS, 1'b0, 2'd0, '0, '0);
        2: add_row(extok_pkg::CH_STAR, 1'b0, 2'd0, '0, '0);
        3: add_row(extok_pkg::CH_SLASH, 1'b0, 2'd0, '0, '0);
        4: add_row(extok_pkg::CH_CARET, 1'b0, 2'd0, '0, '0);
        5: add_row(extok_pkg::CH_LPAR, 1'b0, 2'd0, '0, '0);
        default: add_row(extok_pkg::CH_RPAR, 1'b0, 2'd0, '0, '0);
      endcase
    end else if (sel < 85) begin
      r = $urandom_range(9, 14);
      add_row((r == 14) ? extok_pkg::CH_SPACE : r[7:0], 1'b0, 2'd0, '0, '0);
    end else if (sel < 95) begin
      add_row(8'($urandom_range(0, 255)), 1'b0, 2'd0, '0, '0);
    end else begin
      add_row(8'($urandom_range(0, 255)), 1'b1, 2'd0, '0, '0);
    end
  endtask

  // offer one byte, wait for its transaction, queue its tokens
  task automatic send_item(stim_t row);
    int r;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= row.ch;
    in_tlast  <= row.fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (row.fin) ends_sent++;
    predict_tokens(row.ch, row.fin);
    if (row.n_typed == 2'd0) begin
      foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
    end else begin
      pending_tokens.push_back(row.t0);
      if (row.n_typed == 2'd2) pending_tokens.push_back(row.t1);
    end
    // sender gap: mostly none, some short, a few long
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at token %0d: %s got %0h expected %0h", tok_checked, what, got,
               want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int n_dir;
    scan_st = SCAN_IDLE;
    int_acc = 64'd0;
    frac_acc = 64'd0;
    frac_cnt = 0;
    name_buf = 64'd0;
    name_cnt = 0;
    ovf_pend = 1'b0;
    foreach (kind_seen[i]) kind_seen[i] = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty end, every operator and paren, unknown bytes,
    // trailing point and second point, long name, end after a flush
    add_row(8'hA5, 1, 1,
            tk(extok_pkg::KIND_END, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1), '0);
    add_row(extok_pkg::CH_PLUS, 0, 1,
            tk(extok_pkg::KIND_OP, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1), '0);
    add_row(extok_pkg::CH_MINUS, 0, 1,
            tk(extok_pkg::KIND_OP, 0, 0, 0, extok_pkg::OP_MINUS, 0, 1), '0);
    add_row(extok_pkg::CH_STAR, 0, 1,
            tk(extok_pkg::KIND_OP, 0, 0, 0, extok_pkg::OP_TIMES, 0, 1), '0);
    add_row(extok_pkg::CH_SLASH, 0, 1,
            tk(extok_pkg::KIND_OP, 0, 0, 0, extok_pkg::OP_DIV, 0, 1), '0);
    add_row(extok_pkg::CH_CARET, 0, 1,
            tk(extok_pkg::KIND_OP, 0, 0, 0, extok_pkg::OP_POW, 0, 1), '0);
    add_row(extok_pkg::CH_LPAR, 0, 1,
            tk(extok_pkg::KIND_LP, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1), '0);
    add_row(extok_pkg::CH_RPAR, 0, 1,
            tk(extok_pkg::KIND_RP, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1), '0);
    add_row(8'h00, 0, 1,
            tk(extok_pkg::KIND_UNK, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1), '0);
    add_row(extok_pkg::CH_DOT, 0, 1,
            tk(extok_pkg::KIND_UNK, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1), '0);
    add_text("5.");
    add_row(extok_pkg::CH_DOT, 0, 2,
            tk(extok_pkg::KIND_NUM, 48'h0000_0005_0000, 0, 0, extok_pkg::OP_PLUS, 0, 0),
            tk(extok_pkg::KIND_UNK, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1));
    add_text("abcdefghi");
    add_row(8'hFF, 0, 2,
            tk(extok_pkg::KIND_NAME, 0, 64'h6867_6665_6463_6261, 8, extok_pkg::OP_PLUS,
               1, 0),
            tk(extok_pkg::KIND_UNK, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1));
    add_row(8'h5A, 1, 1,
            tk(extok_pkg::KIND_END, 0, 0, 0, extok_pkg::OP_PLUS, 0, 1), '0);
    n_dir = stim_rows.size();

    // directed rows, then random fragments
    while (bytes_sent < n_dir + RANDOM_ITEMS) begin
      if (stim_rows.size() == 0) gen_fragment();
      calm = (bytes_sent >= n_dir) && ((((bytes_sent - n_dir) / 150) % 4) == 3);
      if (bytes_sent == n_dir + PAUSE_AT) begin
        // let the output side drain completely before continuing
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0) @(posedge clk);
      end
      send_item(stim_rows.pop_front());
    end

    // wait for the last tokens, then a quiet drain period
    in_tvalid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0)
      report_mismatch("tokens never delivered", pending_tokens.size(), 0);

    $display("covered %0d bytes (%0d end markers), %0d tokens checked, %0d flagged",
             bytes_sent, ends_sent, tok_checked, ovf_tokens);
    $display("kinds: num %0d name %0d op %0d lpar %0d rpar %0d unknown %0d end %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6]);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Some tests failed");
    end
    $finish;
  end

  // token receiver: checks each transaction and varies out_tready
  initial begin : receive_tokens
    extok_pkg::tok_t want;
    int              hold_left;
    int              r;
    bit              long_hold_done;
    hold_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready) begin
        tok_checked++;
        if (pending_tokens.size() == 0) begin
          report_mismatch("token with none expected", {61'd0, out_tuser}, 0);
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", out_tuser, want.kind);
          check_field("number_value", out_tdata[47:0], want.num);
          check_field("name_text", out_tdata[111:48], want.text);
          check_field("name_length", out_tdata[115:112], want.len);
          check_field("operator_code", out_tdata[118:116], want.op);
          check_field("overflow_flag", out_tdata[119], want.ovf);
          check_field("last_of_run", out_tlast, want.last);
          kind_seen[int'(want.kind)]++;
          if (want.ovf) ovf_tokens++;
        end
      end
      // ready pattern: one long hold-off, random stalls, calm stretches
      if (rst_n !== 1'b1) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && tok_checked >= 200) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          hold_left = $urandom_range(8, 40);
          out_tready <= 1'b0;
        end else begin
          out_tready <= (r < 75);
        end
      end
    end
  end

  // watchdog: ends the run when no transaction happens for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
